// ===== sv/mcd_pkg.sv =====
// Shared types, opcodes and helpers for the multicycle core with copy engine.
// Depends on nothing; imported by the top level.
package mcd_pkg;

  localparam int MemDepth = 65536;
  localparam int MemAw    = $clog2(MemDepth);

  typedef logic [1:0]  func_t;
  typedef logic [4:0]  opcode_t;
  typedef logic [31:0] word_t;
  typedef logic [7:0][31:0] gp_file_t;

  localparam func_t FN_WRITE = 2'd0;
  localparam func_t FN_TICK  = 2'd1;
  localparam func_t FN_READ  = 2'd2;
  localparam func_t FN_NONE  = 2'd3;

  localparam opcode_t OP_ADD = 5'd0;
  localparam opcode_t OP_SUB = 5'd1;
  localparam opcode_t OP_LSF = 5'd2;
  localparam opcode_t OP_RSF = 5'd3;
  localparam opcode_t OP_AND = 5'd4;
  localparam opcode_t OP_OR  = 5'd5;
  localparam opcode_t OP_XOR = 5'd6;
  localparam opcode_t OP_LHI = 5'd7;
  localparam opcode_t OP_LD  = 5'd8;
  localparam opcode_t OP_ST  = 5'd9;
  localparam opcode_t OP_JLT = 5'd16;
  localparam opcode_t OP_JLE = 5'd17;
  localparam opcode_t OP_JEQ = 5'd18;
  localparam opcode_t OP_JNE = 5'd19;
  localparam opcode_t OP_JIN = 5'd20;
  localparam opcode_t OP_HLT = 5'd24;
  localparam opcode_t OP_DMA = 5'd30;

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_FETCH0 = 3'd1;
  localparam logic [2:0] PH_FETCH1 = 3'd2;
  localparam logic [2:0] PH_DEC0   = 3'd3;
  localparam logic [2:0] PH_DEC1   = 3'd4;
  localparam logic [2:0] PH_EXEC0  = 3'd5;
  localparam logic [2:0] PH_EXEC1  = 3'd6;

  localparam logic [1:0] CP_IDLE = 2'd0;
  localparam logic [1:0] CP_READ = 2'd1;
  localparam logic [1:0] CP_CAPT = 2'd2;
  localparam logic [1:0] CP_WRIT = 2'd3;

  localparam logic [0:0] REG_START = 1'b0;

  // Index 0 reads zero, index 1 the immediate, the rest the register file.
  function automatic word_t reg_read(logic [2:0] idx, word_t imm, gp_file_t regs);
    word_t v;
    if (idx == 3'd1) v = imm;
    else if (idx == 3'd0) v = '0;
    else v = regs[idx];
    return v;
  endfunction

endpackage

// ===== sv/multicycle_cpu_with_dma_unit.sv =====
// Top level: multicycle core, word SRAM, copy engine and two-stage item pipeline.
// Depends on mcd_pkg.
//
//  channel | ports                          | direction
//  in      | in_valid/in_stall, func,addr,wdata | into block
//  out     | out_valid/out_stall, rdata,halted,prog_counter,copy_busy | out of block
//  cfg     | psel,penable,pwrite,paddr,pwdata,prdata,pready | APB register port
//
// One item per clock sustained unless out_stall; an item passes the input register,
// then the execute edge that does the SRAM access, whose read data feeds the result.
// The SRAM has one read and one write port; each item uses at most one of each.
// rst_n is synchronous; it clears control state, the register file and flags.
// A stalled result holds the execute stage, and the input register absorbs one item.
module multicycle_cpu_with_dma_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mcd_pkg::func_t     in_func,
  input  logic [15:0]        in_addr,
  input  logic [31:0]        in_wdata,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        out_rdata,
  output logic               out_halted,
  output logic [15:0]        out_prog_counter,
  output logic               out_copy_busy,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [0:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import mcd_pkg::*;

  // input register
  logic        in_v_r;
  func_t       in_func_r;
  logic [15:0] in_addr_r;
  logic [31:0] in_wdata_r;

  // result register
  logic        out_v_r, out_rd_r, out_halt_r, out_busy_r;
  logic [15:0] out_pc_r;

  // configuration
  logic start_en_r;

  // core state
  gp_file_t    gp_r, gp_nxt;
  logic [15:0] pc_r, pc_nxt;
  word_t       inst_r, inst_nxt;
  opcode_t     op_r, op_nxt;
  logic [2:0]  dst_r, dst_nxt, sra_r, sra_nxt, srb_r, srb_nxt;
  word_t       imm_r, imm_nxt, opa_r, opa_nxt, opb_r, opb_nxt, res_r, res_nxt;
  logic [2:0]  ph_r, ph_nxt;
  logic        halt_r, halt_nxt;
  logic [1:0]  cp_r, cp_nxt;
  logic [15:0] csrc_r, csrc_nxt, cdst_r, cdst_nxt, cleft_r, cleft_nxt;
  word_t       cword_r, cword_nxt;

  // memory and its read data
  word_t       mem [MemDepth];
  word_t       mem_q;
  logic        rd_tick_r;
  word_t       hold_r;
  word_t       dout;

  logic        adv, exec, tick;
  logic        core_rd, core_wr, cp_rd, cp_wr;
  logic [15:0] core_raddr, core_waddr, cp_raddr;
  word_t       core_wdat;
  logic        mem_re, mem_we;
  logic [MemAw-1:0] mem_ra, mem_wa;
  word_t       mem_wd;

  assign adv      = !out_v_r || !out_stall;
  assign exec     = in_v_r && adv;
  assign in_stall = in_v_r && !adv;
  assign tick     = exec && (in_func_r == FN_TICK) && !halt_r;
  assign dout     = rd_tick_r ? mem_q : hold_r;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_START) ? {31'b0, start_en_r} : 32'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_en_r <= 1'b1;
    end else if (psel && penable && pwrite && paddr == REG_START) begin
      start_en_r <= pwdata[0];
    end
  end

  // core next state
  always_comb begin
    word_t a, b;
    a = opa_r;
    b = opb_r;
    gp_nxt = gp_r;  pc_nxt = pc_r;   inst_nxt = inst_r; op_nxt = op_r;
    dst_nxt = dst_r; sra_nxt = sra_r; srb_nxt = srb_r;   imm_nxt = imm_r;
    opa_nxt = opa_r; opb_nxt = opb_r; res_nxt = res_r;   ph_nxt = ph_r;
    halt_nxt = halt_r;
    csrc_nxt = csrc_r; cdst_nxt = cdst_r; cleft_nxt = cleft_r;
    cword_nxt = cword_r; cp_nxt = cp_r;
    core_rd = 1'b0; core_wr = 1'b0; core_raddr = '0; core_waddr = '0; core_wdat = '0;
    cp_rd = 1'b0; cp_wr = 1'b0; cp_raddr = csrc_r;

    case (ph_r)
      PH_IDLE: begin
        pc_nxt = '0;
        if (start_en_r) ph_nxt = PH_FETCH0;
      end
      PH_FETCH0: begin
        core_rd = 1'b1;
        core_raddr = pc_r;
        ph_nxt = PH_FETCH1;
      end
      PH_FETCH1: begin
        inst_nxt = dout;
        ph_nxt = PH_DEC0;
      end
      PH_DEC0: begin
        op_nxt  = inst_r[29:25];
        dst_nxt = inst_r[24:22];
        sra_nxt = inst_r[21:19];
        srb_nxt = inst_r[18:16];
        imm_nxt = {{16{inst_r[15]}}, inst_r[15:0]};
        ph_nxt  = PH_DEC1;
      end
      PH_DEC1: begin
        if (op_r == OP_LHI) begin
          opa_nxt = reg_read(dst_r, imm_r, gp_r);
          opb_nxt = imm_r;
        end else if (op_r == OP_DMA) begin
          cleft_nxt = 16'(reg_read(sra_r, imm_r, gp_r));
          csrc_nxt  = 16'(reg_read(srb_r, imm_r, gp_r));
          cdst_nxt  = 16'(reg_read(dst_r, imm_r, gp_r));
        end else begin
          opa_nxt = reg_read(sra_r, imm_r, gp_r);
          opb_nxt = reg_read(srb_r, imm_r, gp_r);
        end
        ph_nxt = PH_EXEC0;
      end
      PH_EXEC0: begin
        case (op_r)
          OP_ADD: res_nxt = a + b;
          OP_SUB: res_nxt = a - b;
          OP_LSF: res_nxt = a << b[4:0];
          OP_RSF: res_nxt = word_t'($signed(a) >>> b[4:0]);
          OP_AND: res_nxt = a & b;
          OP_OR:  res_nxt = a | b;
          OP_XOR: res_nxt = a ^ b;
          OP_LHI: res_nxt = {b[15:0], a[15:0]};
          OP_LD: begin
            core_rd = 1'b1;
            core_raddr = b[15:0];
          end
          OP_JLT: res_nxt = {31'b0, $signed(a) < $signed(b)};
          OP_JLE: res_nxt = {31'b0, $signed(a) <= $signed(b)};
          OP_JEQ: res_nxt = {31'b0, a == b};
          OP_JNE: res_nxt = {31'b0, a != b};
          default: ;
        endcase
        ph_nxt = PH_EXEC1;
      end
      PH_EXEC1: begin
        if (op_r == OP_HLT) begin
          ph_nxt = PH_IDLE;
          halt_nxt = 1'b1;
        end else begin
          pc_nxt = pc_r + 16'd1;
          if (op_r <= OP_LHI) begin
            gp_nxt[dst_r] = res_r;
          end else if (op_r == OP_LD) begin
            gp_nxt[dst_r] = dout;
          end else if (op_r == OP_ST) begin
            core_wr = 1'b1;
            core_waddr = opb_r[15:0];
            core_wdat = opa_r;
          end else if (op_r >= OP_JLT && op_r <= OP_JNE) begin
            if (res_r != '0) begin
              pc_nxt = imm_r[15:0];
              gp_nxt[7] = {16'b0, pc_r};
            end
          end else if (op_r == OP_JIN) begin
            pc_nxt = opa_r[15:0];
            gp_nxt[7] = {16'b0, pc_r};
          end
          ph_nxt = PH_FETCH0;
        end
      end
      default: ph_nxt = PH_IDLE;
    endcase

    // copy engine: yield the memory port whenever the core uses it
    case (cp_r)
      CP_IDLE: begin
        if (cleft_r != '0) cp_nxt = CP_READ;
      end
      CP_READ: begin
        if (!(ph_r == PH_IDLE || ph_r == PH_FETCH0 ||
              (ph_r == PH_DEC1 && op_r == OP_LD) ||
              (ph_r == PH_EXEC0 && (op_r == OP_LD || op_r == OP_ST)) ||
              ph_r == PH_EXEC1)) begin
          cp_rd = 1'b1;
          cp_nxt = CP_CAPT;
        end
      end
      CP_CAPT: begin
        cword_nxt = dout;
        cp_nxt = CP_WRIT;
      end
      default: begin
        if (!(ph_r == PH_FETCH0 ||
              (ph_r == PH_EXEC0 && op_r == OP_LD) ||
              (ph_r == PH_EXEC1 && (op_r == OP_LD || op_r == OP_ST)))) begin
          cp_wr = 1'b1;
          csrc_nxt  = csrc_r + 16'd1;
          cdst_nxt  = cdst_r + 16'd1;
          cleft_nxt = cleft_r - 16'd1;
          cp_nxt = (cleft_r == 16'd1) ? CP_IDLE : CP_READ;
        end
      end
    endcase
  end

  // memory port selection
  always_comb begin
    mem_re = 1'b0;
    mem_ra = in_addr_r[MemAw-1:0];
    mem_we = 1'b0;
    mem_wa = in_addr_r[MemAw-1:0];
    mem_wd = in_wdata_r;
    if (exec && in_func_r == FN_READ) begin
      mem_re = 1'b1;
    end else if (exec && in_func_r == FN_WRITE) begin
      mem_we = 1'b1;
    end else if (tick) begin
      if (core_rd) begin
        mem_re = 1'b1;
        mem_ra = core_raddr[MemAw-1:0];
      end else if (cp_rd) begin
        mem_re = 1'b1;
        mem_ra = cp_raddr[MemAw-1:0];
      end
      if (core_wr) begin
        mem_we = 1'b1;
        mem_wa = core_waddr[MemAw-1:0];
        mem_wd = core_wdat;
      end else if (cp_wr) begin
        mem_we = 1'b1;
        mem_wa = cdst_r[MemAw-1:0];
        mem_wd = cword_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) mem_q <= mem[mem_ra];
    hold_r <= dout;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r    <= 1'b0;
      out_v_r   <= 1'b0;
      rd_tick_r <= 1'b0;
      gp_r <= '0; pc_r <= '0; inst_r <= '0; op_r <= '0;
      dst_r <= '0; sra_r <= '0; srb_r <= '0; imm_r <= '0;
      opa_r <= '0; opb_r <= '0; res_r <= '0; ph_r <= PH_IDLE;
      halt_r <= 1'b0; cp_r <= CP_IDLE;
      csrc_r <= '0; cdst_r <= '0; cleft_r <= '0; cword_r <= '0;
    end else begin
      if (!in_stall) in_v_r <= in_valid;
      if (adv) out_v_r <= in_v_r;
      if (exec) rd_tick_r <= tick && (core_rd || cp_rd);
      if (tick) begin
        gp_r <= gp_nxt; pc_r <= pc_nxt; inst_r <= inst_nxt; op_r <= op_nxt;
        dst_r <= dst_nxt; sra_r <= sra_nxt; srb_r <= srb_nxt; imm_r <= imm_nxt;
        opa_r <= opa_nxt; opb_r <= opb_nxt; res_r <= res_nxt; ph_r <= ph_nxt;
        halt_r <= halt_nxt; cp_r <= cp_nxt;
        csrc_r <= csrc_nxt; cdst_r <= cdst_nxt; cleft_r <= cleft_nxt;
        cword_r <= cword_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_func_r  <= in_func;
      in_addr_r  <= in_addr;
      in_wdata_r <= in_wdata;
    end
    if (exec) begin
      out_rd_r   <= (in_func_r == FN_READ);
      out_halt_r <= tick ? halt_nxt : halt_r;
      out_pc_r   <= tick ? pc_nxt : pc_r;
      out_busy_r <= tick ? (cp_nxt != CP_IDLE) : (cp_r != CP_IDLE);
    end
  end

  assign out_valid        = out_v_r;
  assign out_rdata        = out_rd_r ? mem_q : '0;
  assign out_halted       = out_halt_r;
  assign out_prog_counter = out_pc_r;
  assign out_copy_busy    = out_busy_r;

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |=> halt_r) else $error("halt flag dropped");
  a_rd_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(tick && core_rd && cp_rd)) else $error("core and copy read together");
  a_wr_port: assert property (@(posedge clk) disable iff (!rst_n)
    !(tick && core_wr && cp_wr)) else $error("core and copy write together");
  a_no_exec_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_stall) |-> !exec) else $error("execute while result held");

endmodule

// ===== sim/mcd_checker.sv =====
// Scoreboard for the multicycle core with copy engine: models the core, SRAM and
// copy engine per transfer and compares every result. Depends on mcd_pkg.
`timescale 1ns / 1ps
module mcd_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  mcd_pkg::func_t     in_func,
  input  logic [15:0]        in_addr,
  input  logic [31:0]        in_wdata,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [31:0]        out_rdata,
  input  logic               out_halted,
  input  logic [15:0]        out_prog_counter,
  input  logic               out_copy_busy,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [0:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  output int                 fail_count,
  output int                 pending
);
  import mcd_pkg::*;

  typedef struct {
    word_t       rdata;
    logic        halted;
    logic [15:0] pc;
    logic        busy;
  } status_t;

  typedef struct {
    gp_file_t    gp;
    logic [15:0] pc;
    word_t       ir, imm, opa, opb, res;
    opcode_t     op;
    logic [2:0]  di, sa, sb, ph;
    logic [1:0]  cph;
    logic [15:0] csrc, cdst, cleft;
    word_t       cword;
  } core_t;

  word_t   sram [MemDepth];
  word_t   sram_dout;
  logic    halt_seen;
  logic    start_en;
  core_t   core;
  status_t status_q[$];

  function automatic word_t operand(logic [2:0] idx);
    if (idx == 3'd1) return core.imm;
    if (idx == 3'd0) return '0;
    return core.gp[idx];
  endfunction

  function automatic void advance_core();
    core_t       n;
    logic        rd, wr, stop;
    logic [15:0] raddr, waddr;
    word_t       wdat, a, b;
    n = core;
    rd = 1'b0; wr = 1'b0; stop = 1'b0;
    raddr = '0; waddr = '0; wdat = '0;
    a = core.opa; b = core.opb;
    case (core.ph)
      PH_IDLE: begin
        n.pc = '0;
        if (start_en) n.ph = PH_FETCH0;
      end
      PH_FETCH0: begin
        rd = 1'b1; raddr = core.pc; n.ph = PH_FETCH1;
      end
      PH_FETCH1: begin
        n.ir = sram_dout; n.ph = PH_DEC0;
      end
      PH_DEC0: begin
        n.op  = core.ir[29:25];
        n.di  = core.ir[24:22];
        n.sa  = core.ir[21:19];
        n.sb  = core.ir[18:16];
        n.imm = {{16{core.ir[15]}}, core.ir[15:0]};
        n.ph  = PH_DEC1;
      end
      PH_DEC1: begin
        if (core.op == OP_LHI) begin
          n.opa = operand(core.di); n.opb = core.imm;
        end else if (core.op == OP_DMA) begin
          n.cleft = 16'(operand(core.sa));
          n.csrc  = 16'(operand(core.sb));
          n.cdst  = 16'(operand(core.di));
        end else begin
          n.opa = operand(core.sa); n.opb = operand(core.sb);
        end
        n.ph = PH_EXEC0;
      end
      PH_EXEC0: begin
        case (core.op)
          OP_ADD: n.res = a + b;
          OP_SUB: n.res = a - b;
          OP_LSF: n.res = a << b[4:0];
          OP_RSF: n.res = $signed(a) >>> b[4:0];
          OP_AND: n.res = a & b;
          OP_OR:  n.res = a | b;
          OP_XOR: n.res = a ^ b;
          OP_LHI: n.res = {b[15:0], a[15:0]};
          OP_LD:  begin rd = 1'b1; raddr = b[15:0]; end
          OP_JLT: n.res = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
          OP_JLE: n.res = ($signed(a) <= $signed(b)) ? 32'd1 : 32'd0;
          OP_JEQ: n.res = (a == b) ? 32'd1 : 32'd0;
          OP_JNE: n.res = (a != b) ? 32'd1 : 32'd0;
          default: ;
        endcase
        n.ph = PH_EXEC1;
      end
      PH_EXEC1: begin
        if (core.op == OP_HLT) begin
          n.ph = PH_IDLE; stop = 1'b1;
        end else begin
          n.pc = core.pc + 16'd1;
          if (core.op <= OP_LHI) n.gp[core.di] = core.res;
          else if (core.op == OP_LD) n.gp[core.di] = sram_dout;
          else if (core.op == OP_ST) begin
            wr = 1'b1; waddr = core.opb[15:0]; wdat = core.opa;
          end else if (core.op >= OP_JLT && core.op <= OP_JNE) begin
            if (core.res != 0) begin
              n.pc = core.imm[15:0]; n.gp[7] = {16'd0, core.pc};
            end
          end else if (core.op == OP_JIN) begin
            n.pc = core.opa[15:0]; n.gp[7] = {16'd0, core.pc};
          end
          n.ph = PH_FETCH0;
        end
      end
      default: n.ph = PH_IDLE;
    endcase

    // copy engine yields the port whenever the core needs it
    case (core.cph)
      CP_IDLE: if (core.cleft != 0) n.cph = CP_READ;
      CP_READ: begin
        if (!(core.ph == PH_IDLE || core.ph == PH_FETCH0 ||
              (core.ph == PH_DEC1 && core.op == OP_LD) ||
              (core.ph == PH_EXEC0 && (core.op == OP_LD || core.op == OP_ST)) ||
              core.ph == PH_EXEC1)) begin
          rd = 1'b1; raddr = core.csrc; n.cph = CP_CAPT;
        end
      end
      CP_CAPT: begin
        n.cword = sram_dout; n.cph = CP_WRIT;
      end
      default: begin
        if (!(core.ph == PH_FETCH0 ||
              (core.ph == PH_EXEC0 && core.op == OP_LD) ||
              (core.ph == PH_EXEC1 && (core.op == OP_LD || core.op == OP_ST)))) begin
          wr = 1'b1; waddr = core.cdst; wdat = core.cword;
          n.csrc  = core.csrc + 16'd1;
          n.cdst  = core.cdst + 16'd1;
          n.cleft = core.cleft - 16'd1;
          n.cph   = (core.cleft == 16'd1) ? CP_IDLE : CP_READ;
        end
      end
    endcase

    // read sees the word before a same-cycle write
    if (rd) sram_dout = sram[raddr];
    if (wr) sram[waddr] = wdat;
    core = n;
    if (stop) halt_seen = 1'b1;
  endfunction

  function automatic status_t apply_transfer(func_t f, logic [15:0] a, word_t w);
    status_t s;
    s.rdata = '0;
    if (f == FN_WRITE) sram[a] = w;
    else if (f == FN_TICK) begin
      if (!halt_seen) advance_core();
    end else if (f == FN_READ) s.rdata = sram[a];
    s.halted = halt_seen;
    s.pc     = core.pc;
    s.busy   = (core.cph != CP_IDLE);
    return s;
  endfunction

  task automatic report(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch on %s: got %h, want %h at %0t", field, got, want, $realtime);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  always @(posedge clk) begin
    status_t want;
    if (!rst_n) begin
      core      = '{default: '0};
      sram_dout = '0;
      halt_seen = 1'b0;
      start_en  = 1'b1;
      status_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == REG_START)
        start_en = pwdata[0];
      if (out_valid && !out_stall) begin
        if (status_q.size() == 0) begin
          $display("unexpected result transfer at %0t", $realtime);
          fail_count++;
        end else begin
          want = status_q.pop_front();
          if (out_rdata !== want.rdata) report("rdata", out_rdata, want.rdata);
          if (out_halted !== want.halted)
            report("halted", 32'(out_halted), 32'(want.halted));
          if (out_prog_counter !== want.pc)
            report("prog_counter", 32'(out_prog_counter), 32'(want.pc));
          if (out_copy_busy !== want.busy)
            report("copy_busy", 32'(out_copy_busy), 32'(want.busy));
        end
      end
      if (in_valid && !in_stall)
        status_q.push_back(apply_transfer(in_func, in_addr, in_wdata));
    end
    pending = status_q.size();
  end

endmodule

// ===== sim/multicycle_cpu_with_dma_unit_test.sv =====
// Stimulus and verdict for multicycle_cpu_with_dma_unit: loads programs into the
// SRAM, clocks the core, reads back. Depends on mcd_pkg and mcd_checker.
`timescale 1ns / 1ps
module multicycle_cpu_with_dma_unit_test;
  import mcd_pkg::*;

  localparam int CycleLimit = 2000000;
  localparam logic [15:0] DataBase = 16'h0400;
  localparam int DataWords = 32;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  func_t       in_func = FN_TICK;
  logic [15:0] in_addr = '0;
  logic [31:0] in_wdata = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_rdata;
  logic        out_halted;
  logic [15:0] out_prog_counter;
  logic        out_copy_busy;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [0:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          pending;
  int          cycles = 0;
  logic        gaps_on = 1'b1;

  multicycle_cpu_with_dma_unit dut (.*);

  mcd_checker checker_i (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= gaps_on && ($urandom_range(99) < 8);
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("** multicycle_cpu_with_dma_unit: FAILED **");
      $finish;
    end
  end

  function automatic word_t encode(opcode_t op, logic [2:0] d, logic [2:0] a,
                                   logic [2:0] b, logic [15:0] imm);
    return {2'b00, op, d, a, b, imm};
  endfunction

  // data window: seeded before use, never fetched or copied by the program
  function automatic logic [15:0] data_addr();
    return DataBase + 16'($urandom_range(DataWords - 1));
  endfunction

  task automatic send(func_t f, logic [15:0] a, word_t w);
    while (gaps_on && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func  <= f;
    in_addr  <= a;
    in_wdata <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // hold input until every result is back, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_start(logic v);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= REG_START; pwdata <= {31'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    word_t  prog[14];
    int     r;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_start(1'b0);

    // core held idle: extremes and the unused code
    send(FN_WRITE, 16'hFFFF, 32'hFFFF_FFFF);
    send(FN_READ, 16'hFFFF, 32'h0);
    send(FN_WRITE, 16'h0000, 32'h0);
    send(FN_READ, 16'h0000, 32'hFFFF_FFFF);
    send(FN_NONE, 16'hFFFF, 32'hFFFF_FFFF);
    send(FN_TICK, 16'h0, 32'h0);
    send(FN_TICK, 16'h0, 32'h0);
    for (int i = 0; i < DataWords; i++)
      send(FN_WRITE, DataBase + 16'(i), $urandom);
    drain();
    set_start(1'b1);

    // loop over words 0..13; besides those it touches only word 200 and,
    // through the copy engine, words 0..3 and 0xFFFF
    prog = '{encode(OP_ADD, 3'd2, 3'd1, 3'd0, 16'hFFFF),
             encode(OP_ADD, 3'd3, 3'd1, 3'd0, 16'd5),
             encode(OP_SUB, 3'd4, 3'd2, 3'd3, 16'd0),
             encode(OP_LSF, 3'd5, 3'd2, 3'd1, 16'd33),
             encode(OP_RSF, 3'd6, 3'd2, 3'd3, 16'd0),
             encode(OP_XOR, 3'd4, 3'd4, 3'd1, 16'h8000),
             encode(OP_LHI, 3'd5, 3'd0, 3'd0, 16'h1234),
             encode(OP_ST,  3'd0, 3'd3, 3'd1, 16'd200),
             encode(OP_LD,  3'd6, 3'd0, 3'd1, 16'd200),
             encode(OP_DMA, 3'd2, 3'd1, 3'd0, 16'd4),
             encode(OP_JEQ, 3'd0, 3'd0, 3'd0, 16'd12),
             encode(OP_OR,  3'd1, 3'd2, 3'd2, 16'd0),
             encode(OP_JLT, 3'd0, 3'd2, 3'd0, 16'd13),
             encode(OP_JIN, 3'd0, 3'd1, 3'd0, 16'd0)};
    foreach (prog[i]) send(FN_WRITE, 16'(i), prog[i]);

    for (int n = 0; n < 900; n++) begin
      gaps_on = !(n >= 400 && n < 600);
      if (n == 500) begin
        drain();
        set_start(1'b0);
        set_start(1'b1);
      end
      r = $urandom_range(99);
      if (r < 70) send(FN_TICK, 16'($urandom), $urandom);
      else if (r < 82) send(FN_WRITE, data_addr(), $urandom);
      else if (r < 94) send(FN_READ, data_addr(), $urandom);
      else send(FN_NONE, 16'($urandom), $urandom);
    end

    // overwrite the loop with halts so the core stops, then poke SRAM after the halt
    drain();
    for (int i = 0; i < 14; i++)
      send(FN_WRITE, 16'(i), encode(OP_HLT, 3'd0, 3'd0, 3'd0, 16'd0));
    send(FN_WRITE, 16'hFFFF, encode(OP_HLT, 3'd0, 3'd0, 3'd0, 16'd0));
    repeat (60) send(FN_TICK, 16'h0, 32'h0);
    repeat (10) begin
      send(FN_WRITE, data_addr(), $urandom);
      send(FN_READ, data_addr(), 32'h0);
      send(FN_TICK, 16'h0, 32'h0);
    end
    drain();
    if (fail_count == 0) begin
      $display("** multicycle_cpu_with_dma_unit: PASSED **");
    end else begin
      $display("** multicycle_cpu_with_dma_unit: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/mcd_pkg.sv
sv/multicycle_cpu_with_dma_unit.sv
sim/mcd_checker.sv
sim/multicycle_cpu_with_dma_unit_test.sv
